// ----- hw/rtl/swmm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared types and constants of the sliding window min/max block.
// ----------------------------------------------------------------------------
package swmm_pkg;

    localparam int WINDOW_MAX = 1024;
    localparam int DATA_W     = 32;
    // Positions count modulo twice the largest window.
    localparam int POS_W      = $clog2(2 * WINDOW_MAX);
    localparam int WIN_W      = 11;
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(3);
    localparam logic [WIN_W-1:0] WIN_LIMIT = WIN_W'(WINDOW_MAX);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(WINDOW_MAX);

    typedef logic signed [DATA_W-1:0] sample_t;
    typedef logic [POS_W-1:0]         pos_t;

    typedef struct packed {
        logic    valid;
        sample_t value;
        pos_t    pos;
    } entry_t;

    // Control broadcast from the top level to every cell of a queue.
    typedef struct packed {
        logic    step;
        logic    clear;
        sample_t sample;
        pos_t    pos;
    } cell_ctrl_t;

endpackage

// ----- hw/rtl/swmm_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmm_in_if
// Input channel: one sample word with its sequence flags.
// ----------------------------------------------------------------------------
interface swmm_in_if;
    logic                    valid;
    logic                    ready;
    logic signed [31:0]      sample;
    logic                    first_sample;
    logic                    last_sample;

    modport source (output valid, output sample, output first_sample,
                    output last_sample, input ready);
    modport sink   (input valid, input sample, input first_sample,
                    input last_sample, output ready);
endinterface

// ----- hw/rtl/swmm_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmm_out_if
// Output channel: one window result word.
// ----------------------------------------------------------------------------
interface swmm_out_if;
    logic                    valid;
    logic                    ready;
    logic signed [31:0]      window_min;
    logic signed [31:0]      window_max;
    logic                    partial_window;

    modport source (output valid, output window_min, output window_max,
                    output partial_window, input ready);
    modport sink   (input valid, input window_min, input window_max,
                    input partial_window, output ready);
endinterface

// ----- hw/rtl/swmm_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmm_cell
// One slot of a monotonic queue. Takes over its right neighbor on a front
// drop, drops itself when dominated, and takes the new sample when it is
// the first free slot behind the surviving entries.
// ----------------------------------------------------------------------------
module swmm_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 is_max,
    input  logic                 shift,
    input  swmm_pkg::cell_ctrl_t ctrl,
    input  swmm_pkg::entry_t     right_q,
    input  logic                 left_surv,
    output swmm_pkg::entry_t     q,
    output swmm_pkg::entry_t     nxt,
    output logic                 surv
);
    import swmm_pkg::*;

    logic    valid_reg;
    sample_t value_reg;
    pos_t    pos_reg;
    entry_t  cur;
    entry_t  ent_next;
    entry_t  eff;
    logic    dom;

    assign cur = '{valid: valid_reg, value: value_reg, pos: pos_reg};

    always_comb
    begin
        eff  = shift ? right_q : cur;
        dom  = is_max ? ($signed(ctrl.sample) >= $signed(eff.value))
                      : ($signed(ctrl.sample) <= $signed(eff.value));
        surv = eff.valid && !ctrl.clear && !dom;

        ent_next = cur;
        if (ctrl.step)
        begin
            if (!surv && left_surv)
            begin
                ent_next.valid = 1'b1;
                ent_next.value = ctrl.sample;
                ent_next.pos   = ctrl.pos;
            end
            else if (surv)
            begin
                ent_next = eff;
            end
            else
            begin
                ent_next.valid = 1'b0;
            end
        end
        else if (shift)
        begin
            ent_next = eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ent_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= ent_next.value;
        pos_reg   <= ent_next.pos;
    end

    assign q   = cur;
    assign nxt = ent_next;

endmodule

// ----- hw/rtl/swmm_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmm_queue
// Row of cells forming one monotonic queue; the front sits in cell 0.
// ----------------------------------------------------------------------------
module swmm_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 is_max,
    input  logic                 shift,
    input  swmm_pkg::cell_ctrl_t ctrl,
    output swmm_pkg::entry_t     front0,
    output swmm_pkg::entry_t     front1,
    output swmm_pkg::sample_t    head_next
);
    import swmm_pkg::*;

    entry_t q_arr   [WINDOW_MAX];
    entry_t nxt_arr [WINDOW_MAX];
    logic   surv_arr[WINDOW_MAX];

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        entry_t right_q;
        logic   left_surv;

        if (i == WINDOW_MAX - 1)
        begin : g_tail
            assign right_q = '0;
        end
        else
        begin : g_mid
            assign right_q = q_arr[i+1];
        end

        if (i == 0)
        begin : g_head
            assign left_surv = 1'b1;
        end
        else
        begin : g_body
            assign left_surv = surv_arr[i-1];
        end

        swmm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .is_max    (is_max),
            .shift     (shift),
            .ctrl      (ctrl),
            .right_q   (right_q),
            .left_surv (left_surv),
            .q         (q_arr[i]),
            .nxt       (nxt_arr[i]),
            .surv      (surv_arr[i])
        );
    end

    assign front0    = q_arr[0];
    assign front1    = q_arr[1];
    assign head_next = nxt_arr[0].value;

endmodule

// ----- hw/rtl/sliding_window_min_max.sv -----
`timescale 1ns / 1ps
// Output: a result word is registered when its sample is accepted.
// Throughput: one sample per cycle while the output register is free and no purge
// runs; cells compare with the new sample in parallel, so back pops never stall.
// After a window shrink, each expired entry beyond the first, in whichever queue
// holds more of them, costs a purge stall, since a front drops one cell a cycle.
// Reset: asynchronous; queues empty, window size 3, no result pending.
// ----------------------------------------------------------------------------
// sliding_window_min_max
// Sliding window minimum and maximum over a stream of signed samples, using
// two monotonic queues built as rows of cells.
// ----------------------------------------------------------------------------
module sliding_window_min_max (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [swmm_pkg::WIN_W-1:0]  cfg_wr_data,
    swmm_in_if.sink                     in_ch,
    swmm_out_if.source                  out_ch
);
    import swmm_pkg::*;

    logic [WIN_W-1:0] win_reg;
    logic [WIN_W-1:0] win_eff;
    pos_t             sp_reg;
    pos_t             sp_next;
    logic [CNT_W-1:0] seen_reg;
    logic [CNT_W-1:0] seen_next;
    logic [CNT_W-1:0] seen_base;
    logic             restart_reg;
    logic             restart_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    sample_t          out_min_reg;
    sample_t          out_max_reg;
    logic             out_partial_reg;

    entry_t           min_f0, min_f1, max_f0, max_f1;
    sample_t          min_head, max_head;
    logic             min_exp0, min_exp1, max_exp0, max_exp1;
    logic             clear;
    logic             purge;
    logic             out_free;
    logic             accept;
    logic             full;
    logic             emit;
    logic             min_shift, max_shift;
    cell_ctrl_t       ctrl;

    function automatic logic expired(entry_t e, pos_t cur, logic [WIN_W-1:0] win);
        pos_t age;
        age = cur - e.pos;
        return e.valid && ({1'b0, age} >= {{(POS_W + 1 - WIN_W){1'b0}}, win});
    endfunction

    always_comb
    begin
        if (win_reg == '0)
        begin
            win_eff = WIN_W'(1);
        end
        else if (win_reg > WIN_LIMIT)
        begin
            win_eff = WIN_LIMIT;
        end
        else
        begin
            win_eff = win_reg;
        end
    end

    assign min_exp0 = expired(min_f0, sp_reg, win_eff);
    assign min_exp1 = expired(min_f1, sp_reg, win_eff);
    assign max_exp0 = expired(max_f0, sp_reg, win_eff);
    assign max_exp1 = expired(max_f1, sp_reg, win_eff);

    // A sample after a last word starts a new sequence just like a first word.
    assign clear    = in_ch.first_sample || restart_reg;
    // More than one expired entry at a front: drop one per cycle first.
    assign purge    = in_ch.valid && !clear && (min_exp1 || max_exp1);
    assign out_free = !out_valid_reg || out_ch.ready;
    assign accept   = in_ch.valid && !purge && out_free;
    assign in_ch.ready = !purge && out_free;

    assign min_shift = accept ? (!clear && min_exp0) : (purge && min_exp1);
    assign max_shift = accept ? (!clear && max_exp0) : (purge && max_exp1);

    always_comb
    begin
        ctrl.step   = accept;
        ctrl.clear  = clear;
        ctrl.sample = in_ch.sample;
        ctrl.pos    = clear ? '0 : sp_reg;

        seen_base = clear ? '0 : seen_reg;
        seen_next = (seen_base == CNT_LIMIT) ? CNT_LIMIT : seen_base + CNT_W'(1);
        full      = (WIN_W'(seen_next) >= win_eff);
        emit      = full || in_ch.last_sample;
        sp_next   = ctrl.pos + POS_W'(1);

        restart_next   = restart_reg;
        out_valid_next = out_valid_reg;
        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            restart_next = in_ch.last_sample;
            if (emit)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    swmm_queue u_min_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .is_max    (1'b0),
        .shift     (min_shift),
        .ctrl      (ctrl),
        .front0    (min_f0),
        .front1    (min_f1),
        .head_next (min_head)
    );

    swmm_queue u_max_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .is_max    (1'b1),
        .shift     (max_shift),
        .ctrl      (ctrl),
        .front0    (max_f0),
        .front1    (max_f1),
        .head_next (max_head)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= WIN_RESET;
            sp_reg        <= '0;
            seen_reg      <= '0;
            restart_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                win_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                sp_reg   <= sp_next;
                seen_reg <= seen_next;
            end
            restart_reg   <= restart_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_min_reg     <= min_head;
            out_max_reg     <= max_head;
            out_partial_reg <= !full;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.window_min     = out_min_reg;
    assign out_ch.window_max     = out_max_reg;
    assign out_ch.partial_window = out_partial_reg;

    // Every accepted sample lands in both queues.
    a_fronts_filled: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (min_f0.valid && max_f0.valid))
        else $error("queue front empty after a sample");

    // Both fronts describe the same window right after a sample.
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        $past(accept) |-> ($signed(min_f0.value) <= $signed(max_f0.value)))
        else $error("window minimum above window maximum");

    // Queue order: strictly increasing for min, strictly decreasing for max.
    a_min_order: assert property (@(posedge clk) disable iff (!rst_n)
        min_f1.valid |-> (min_f0.valid && ($signed(min_f1.value) > $signed(min_f0.value))))
        else $error("min queue out of order");

    a_max_order: assert property (@(posedge clk) disable iff (!rst_n)
        max_f1.valid |-> (max_f0.valid && ($signed(max_f1.value) < $signed(max_f0.value))))
        else $error("max queue out of order");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= CNT_LIMIT)
        else $error("sample count beyond window limit");

endmodule
